@@ src/tsr_pkg.sv @@
`default_nettype none

package tsr_pkg;

    localparam int WordW      = 32;
    localparam int AccW       = 24;
    localparam int OffsetW    = 26;
    localparam int AddrW      = 27;
    localparam int IndexW     = 21;
    localparam int SlotW      = 10;
    localparam int RhsCountW  = 11;
    localparam int CellCountW = 21;
    localparam int CfgIndexW  = 2;
    localparam int CfgDataW   = 27;
    localparam int QueueDepth = 4;

    localparam logic [OffsetW-1:0] OffsetReset  = 26'h07B98A0;
    localparam logic [AddrW-1:0]   LimitReset   = 27'h7FFFFFF;
    localparam logic [IndexW-1:0]  WordIndexMax = 21'h1FFFFF;
    localparam logic [1:0]         LastPhase    = 2'd3;

    localparam logic [CfgIndexW-1:0] REG_STORE_OFFSET = 2'd0;
    localparam logic [CfgIndexW-1:0] REG_STORE_LIMIT  = 2'd1;

    typedef enum logic [1:0] {
        KIND_ROWS = 2'd0,
        KIND_COLS = 2'd1,
        KIND_CELL = 2'd2
    } tsr_kind_t;

    typedef struct packed {
        logic             restart;
        logic [WordW-1:0] word;
    } tsr_entry_t;

endpackage

`default_nettype wire

@@ src/tsr_if.sv @@
`default_nettype none

interface tsr_byte_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] data_byte;

    modport source (output valid, action, data_byte, input ready);
    modport sink (input valid, action, data_byte, output ready);
endinterface

interface tsr_word_if;
    logic        valid;
    logic        ready;
    logic [31:0] word_value;
    logic [1:0]  word_kind;
    logic [26:0] store_address;
    logic        rhs_write;
    logic [9:0]  rhs_index;
    logic        obj_write;
    logic [9:0]  obj_index;
    logic        out_of_room;
    logic        start_solver;
    logic [20:0] cell_count;

    modport source (output valid, word_value, word_kind, store_address, rhs_write, rhs_index,
                    obj_write, obj_index, out_of_room, start_solver, cell_count,
                    input ready);
    modport sink (input valid, word_value, word_kind, store_address, rhs_write, rhs_index,
                  obj_write, obj_index, out_of_room, start_solver, cell_count,
                  output ready);
endinterface

interface tsr_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [26:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ src/tsr_front.sv @@
`default_nettype none

module tsr_front
    import tsr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    tsr_byte_if.sink        bytes,
    output tsr_entry_t      push_entry,
    output logic            push_valid,
    input  wire logic       push_ready
);

    logic [1:0]     phase_reg;
    logic [1:0]     phase_next;
    logic [AccW-1:0] acc_reg;
    logic [AccW-1:0] acc_next;
    logic           accept;

    assign bytes.ready        = push_ready;
    assign accept             = bytes.valid && push_ready;
    assign push_valid         = bytes.valid && (bytes.action || phase_reg == LastPhase);
    assign push_entry.restart = bytes.action;
    assign push_entry.word    = {acc_reg, bytes.data_byte};

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        if (accept)
        begin
            if (bytes.action || phase_reg == LastPhase)
            begin
                phase_next = '0;
                acc_next   = '0;
            end
            else
            begin
                phase_next = phase_reg + 2'd1;
                acc_next   = {acc_reg[AccW-9:0], bytes.data_byte};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            acc_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
        end
    end

endmodule

`default_nettype wire

@@ src/tsr_queue.sv @@
`default_nettype none

module tsr_queue
    import tsr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire tsr_entry_t push_entry,
    input  wire logic       push_valid,
    output logic            push_ready,
    output tsr_entry_t      pop_entry,
    output logic            pop_valid,
    input  wire logic       pop_ready
);

    localparam int PtrW   = $clog2(QueueDepth);
    localparam int CountW = $clog2(QueueDepth + 1);

    tsr_entry_t        slot_reg [QueueDepth];
    logic [PtrW-1:0]   wr_ptr_reg;
    logic [PtrW-1:0]   rd_ptr_reg;
    logic [CountW-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = count_reg != CountW'(QueueDepth);
    assign pop_valid  = count_reg != '0;
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PtrW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PtrW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CountW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CountW'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ src/tsr_back.sv @@
`default_nettype none

module tsr_back
    import tsr_pkg::*;
#(
    parameter int MAX_ROWS = 1024,
    parameter int MAX_COLS = 1024
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire tsr_entry_t pop_entry,
    input  wire logic       pop_valid,
    output logic            pop_ready,
    tsr_cfg_if.sink         cfg,
    tsr_word_if.source      words
);

    localparam int RW   = $clog2(MAX_ROWS + 1);
    localparam int CW   = $clog2(MAX_COLS + 1);
    localparam int PW   = RW + CW;
    localparam int CmpW = ((PW > IndexW) ? PW : IndexW) + 1;
    localparam int ObjW = (CW > SlotW) ? CW : SlotW;
    localparam logic [WordW-1:0] MaxRowsW = WordW'(MAX_ROWS);
    localparam logic [WordW-1:0] MaxColsW = WordW'(MAX_COLS);

    typedef struct packed {
        logic [WordW-1:0]      word_value;
        tsr_kind_t             word_kind;
        logic [AddrW-1:0]      store_address;
        logic                  rhs_write;
        logic [SlotW-1:0]      rhs_index;
        logic                  obj_write;
        logic [SlotW-1:0]      obj_index;
        logic                  out_of_room;
        logic                  start_solver;
        logic [CellCountW-1:0] cell_count;
    } result_t;

    logic [OffsetW-1:0]   offset_reg, offset_next;
    logic [AddrW-1:0]     limit_reg, limit_next;
    logic [IndexW-1:0]    widx_reg, widx_next;
    logic [RW-1:0]        row_reg, row_next;
    logic [CW-1:0]        col_reg, col_next;
    logic [CW-1:0]        colpos_reg, colpos_next;
    logic [RhsCountW-1:0] rhs_cnt_reg, rhs_cnt_next;
    logic [CW-1:0]        obj_cnt_reg, obj_cnt_next;
    logic [PW-1:0]        cells_reg, cells_next;
    logic                 valid_reg, valid_next;
    result_t              res_reg, res_next;

    logic                 pop;
    logic [WordW-1:0]     word;
    logic [RW-1:0]        row_clamp;
    logic [CW-1:0]        col_clamp;
    logic [CW:0]          colpos_inc;
    logic [CmpW-1:0]      cells_ext;
    logic [ObjW-1:0]      obj_ext;
    logic [AddrW-1:0]     addr;

    assign pop        = pop_valid && pop_ready;
    assign pop_ready  = !valid_reg || words.ready;
    assign cfg.ready  = 1'b1;
    assign word       = pop_entry.word;
    assign row_clamp  = (word > MaxRowsW) ? RW'(MAX_ROWS) : word[RW-1:0];
    assign col_clamp  = (word > MaxColsW) ? CW'(MAX_COLS) : word[CW-1:0];
    assign colpos_inc = (CW+1)'(colpos_reg) + (CW+1)'(1);
    assign cells_ext  = CmpW'(cells_reg);
    assign obj_ext    = ObjW'(obj_cnt_reg);
    assign addr       = AddrW'(offset_reg) + AddrW'(widx_reg);

    always_comb
    begin
        offset_next  = offset_reg;
        limit_next   = limit_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_STORE_OFFSET: offset_next = cfg.data[OffsetW-1:0];
                REG_STORE_LIMIT:  limit_next  = cfg.data;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        widx_next    = widx_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        colpos_next  = colpos_reg;
        rhs_cnt_next = rhs_cnt_reg;
        obj_cnt_next = obj_cnt_reg;
        cells_next   = cells_reg;
        valid_next   = valid_reg && !words.ready;
        res_next     = res_reg;

        if (pop && pop_entry.restart)
        begin
            widx_next    = '0;
            row_next     = '0;
            col_next     = '0;
            colpos_next  = '0;
            rhs_cnt_next = '0;
            obj_cnt_next = '0;
            cells_next   = '0;
        end
        else if (pop)
        begin
            valid_next             = 1'b1;
            res_next.word_value    = word;
            res_next.word_kind     = KIND_CELL;
            res_next.store_address = addr;
            res_next.rhs_write     = 1'b0;
            res_next.rhs_index     = '0;
            res_next.obj_write     = 1'b0;
            res_next.obj_index     = '0;
            res_next.out_of_room   = addr > limit_reg;
            res_next.start_solver  = 1'b0;
            res_next.cell_count    = '0;

            if (widx_reg == IndexW'(0))
            begin
                res_next.word_kind = KIND_ROWS;
                row_next           = row_clamp;
            end
            else if (widx_reg == IndexW'(1))
            begin
                res_next.word_kind = KIND_COLS;
                col_next           = col_clamp;
                cells_next         = PW'(row_reg) * PW'(col_clamp);
            end
            else if (col_reg != '0)
            begin
                if (colpos_inc >= (CW+1)'(col_reg))
                begin
                    res_next.rhs_write = 1'b1;
                    res_next.rhs_index = rhs_cnt_reg[SlotW-1:0];
                    rhs_cnt_next       = rhs_cnt_reg + RhsCountW'(1);
                    colpos_next        = '0;
                end
                else
                begin
                    colpos_next = colpos_inc[CW-1:0];
                end
                if (obj_cnt_reg < col_reg)
                begin
                    res_next.obj_write = 1'b1;
                    res_next.obj_index = obj_ext[SlotW-1:0];
                    obj_cnt_next       = obj_cnt_reg + CW'(1);
                end
            end

            if (widx_reg != WordIndexMax)
            begin
                widx_next = widx_reg + IndexW'(1);
                if (widx_reg == IndexW'(1))
                begin
                    res_next.start_solver = (row_reg == '0) || (col_clamp == '0);
                end
                else if (widx_reg != IndexW'(0))
                begin
                    if (CmpW'(widx_reg) + CmpW'(1) == cells_ext + CmpW'(2))
                    begin
                        res_next.start_solver = 1'b1;
                        res_next.cell_count   = cells_ext[CellCountW-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg  <= OffsetReset;
            limit_reg   <= LimitReset;
            widx_reg    <= '0;
            row_reg     <= '0;
            col_reg     <= '0;
            colpos_reg  <= '0;
            rhs_cnt_reg <= '0;
            obj_cnt_reg <= '0;
            cells_reg   <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            offset_reg  <= offset_next;
            limit_reg   <= limit_next;
            widx_reg    <= widx_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            colpos_reg  <= colpos_next;
            rhs_cnt_reg <= rhs_cnt_next;
            obj_cnt_reg <= obj_cnt_next;
            cells_reg   <= cells_next;
            valid_reg   <= valid_next;
        end
    end

    assign words.valid         = valid_reg;
    assign words.word_value    = res_reg.word_value;
    assign words.word_kind     = res_reg.word_kind;
    assign words.store_address = res_reg.store_address;
    assign words.rhs_write     = res_reg.rhs_write;
    assign words.rhs_index     = res_reg.rhs_index;
    assign words.obj_write     = res_reg.obj_write;
    assign words.obj_index     = res_reg.obj_index;
    assign words.out_of_room   = res_reg.out_of_room;
    assign words.start_solver  = res_reg.start_solver;
    assign words.cell_count    = res_reg.cell_count;

endmodule

`default_nettype wire

@@ src/tableau_stream_router_unit.sv @@
`default_nettype none

// Tableau stream router. Takes byte beats on bytes and packs every four data bytes, most
// significant first, into a word; each word leaves on words as one beat via the queue and
// the output register, tagged as row count, column count or cell, with its external store
// address, right-hand-side and objective slots, an out-of-room flag, and a start flag with
// the cell count on the word that completes the tableau, or on the column count word of an
// empty tableau. A restart beat clears all counters in order with the words ahead of it and
// gives no output. Sustained rate is one byte per clock while words is not stalled, set by
// the byte packer; a four-word queue between packer and router absorbs stalls on words.
// Write store_offset and store_limit on cfg only while no words are in flight.
module tableau_stream_router_unit
    import tsr_pkg::*;
#(
    parameter int MAX_ROWS = 1024,
    parameter int MAX_COLS = 1024
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    tsr_byte_if.sink   bytes,
    tsr_word_if.source words,
    tsr_cfg_if.sink    cfg
);

    tsr_entry_t push_entry;
    logic       push_valid;
    logic       push_ready;
    tsr_entry_t pop_entry;
    logic       pop_valid;
    logic       pop_ready;

    tsr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .bytes      (bytes),
        .push_entry (push_entry),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    tsr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_entry (push_entry),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_entry  (pop_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    tsr_back #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_entry (pop_entry),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .cfg       (cfg),
        .words     (words)
    );

endmodule

`default_nettype wire

@@ src/tsr_checker.sv @@
`default_nettype none

module tsr_checker
    import tsr_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] word_value,
    input wire logic [1:0]  word_kind,
    input wire logic        rhs_write,
    input wire logic        obj_write,
    input wire logic        start_solver,
    input wire logic [20:0] cell_count
);

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("word beat dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(word_value) && $stable(word_kind))
        else $error("word beat changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && word_kind != KIND_CELL |-> !rhs_write && !obj_write)
        else $error("store write on a header word");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !start_solver |-> cell_count == '0)
        else $error("cell count without start");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && start_solver |-> word_kind != KIND_ROWS)
        else $error("start on row count word");

endmodule

bind tableau_stream_router_unit tsr_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (words.valid),
    .out_ready    (words.ready),
    .word_value   (words.word_value),
    .word_kind    (words.word_kind),
    .rhs_write    (words.rhs_write),
    .obj_write    (words.obj_write),
    .start_solver (words.start_solver),
    .cell_count   (words.cell_count)
);

`default_nettype wire
